@@ rtl/mwcd_pkg.sv @@
package mwcd_pkg;

  // Unit width codes; code 3 decodes as 8-bit units
  localparam logic [1:0] UW_8  = 2'd0;
  localparam logic [1:0] UW_16 = 2'd1;
  localparam logic [1:0] UW_32 = 2'd2;

  // Register indexes on the configuration port
  localparam logic REG_UNIT_WIDTH    = 1'b0;
  localparam logic REG_DECODE_ENABLE = 1'b1;

  localparam int unsigned Q_DEPTH = 4;
  localparam int unsigned Q_PTR_W = $clog2(Q_DEPTH);
  localparam int unsigned Q_CNT_W = $clog2(Q_DEPTH + 1);

  localparam logic [31:0] REPL_CP     = 32'h0000_FFFD;
  localparam logic [31:0] SUPP_BASE   = 32'h0001_0000;
  localparam logic [15:0] SUR_HI_BASE = 16'hD800;
  localparam logic [15:0] SUR_LO_BASE = 16'hDC00;
  localparam logic [15:0] SUR_END     = 16'hE000;
  localparam logic [7:0]  LEAD_BAD    = 8'hFE;

  // Marker bit still present at each stage, and smallest legal value
  localparam logic [31:0] CTRL_BIT [8] = '{
    32'h0000_0800, 32'h0001_0000, 32'h0020_0000, 32'h0400_0000,
    32'h8000_0000, 32'h0, 32'h0, 32'h0
  };
  localparam logic [31:0] MIN_VAL [8] = '{
    32'h0000_0080, 32'h0000_0800, 32'h0001_0000, 32'h0020_0000,
    32'h0400_0000, 32'h8000_0000, 32'h0, 32'h0
  };

  typedef struct packed {
    logic [1:0] unit_width;
    logic       decode_enable;
  } cfg_t;

  typedef struct packed {
    logic [31:0] code_point;
    logic [2:0]  unit_bytes;
    logic        is_replacement;
    logic        last;
  } res_t;

  typedef struct packed {
    logic [31:0] acc;
    logic [2:0]  stage;
    logic [2:0]  taken;
    logic        seq_pend;
    logic [9:0]  high_sur;
    logic        sur_pend;
  } dec_state_t;

endpackage

@@ rtl/mwcd_regs.sv @@
module mwcd_regs (
  input  logic          clk,
  input  logic          rst,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [2:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready,
  output mwcd_pkg::cfg_t cfg,
  output logic          cfg_wr
);
  import mwcd_pkg::*;

  logic idx;

  assign idx    = paddr[2];
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.unit_width    <= UW_8;
      cfg.decode_enable <= 1'b1;
    end else if (cfg_wr) begin
      case (idx)
        REG_UNIT_WIDTH:    cfg.unit_width    <= pwdata[1:0];
        REG_DECODE_ENABLE: cfg.decode_enable <= pwdata[0];
        default:           cfg.unit_width    <= cfg.unit_width;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_UNIT_WIDTH:    prdata = {30'd0, cfg.unit_width};
      REG_DECODE_ENABLE: prdata = {31'd0, cfg.decode_enable};
      default:           prdata = '0;
    endcase
  end

endmodule

@@ rtl/mwcd_decode.sv @@
module mwcd_decode (
  input  logic           clk,
  input  logic           rst,
  input  mwcd_pkg::cfg_t cfg,
  input  logic           clear,
  input  logic           fire,
  input  logic [31:0]    unit,
  output mwcd_pkg::res_t r0,
  output mwcd_pkg::res_t r1,
  output logic [1:0]     n
);
  import mwcd_pkg::*;

  dec_state_t st, st_next;

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      st <= '0;
    end else if (fire) begin
      st <= st_next;
    end
  end

  logic [15:0] u16;
  logic [7:0]  b;
  logic        broke;
  res_t        fr;
  logic        fr_emit;
  res_t        head;
  logic        head_emit;
  logic [31:0] code;
  logic [2:0]  len;

  always_comb begin
    u16       = unit[15:0];
    b         = unit[7:0];
    st_next   = st;
    broke     = 1'b0;
    fr        = '0;
    fr_emit   = 1'b0;
    head      = '0;
    head_emit = 1'b0;
    code      = {st.acc[25:0], b[5:0]};
    len       = st.taken + 3'd1;

    case (cfg.unit_width)
      UW_32: begin
        head      = '{code_point: unit, unit_bytes: 3'd4, is_replacement: 1'b0, last: 1'b0};
        head_emit = 1'b1;
      end
      UW_16: begin
        if (!cfg.decode_enable) begin
          head      = '{code_point: {16'd0, u16}, unit_bytes: 3'd2,
                        is_replacement: 1'b0, last: 1'b0};
          head_emit = 1'b1;
        end else begin
          if (st.sur_pend) begin
            st_next = '0;
            if (u16 >= SUR_LO_BASE && u16 < SUR_END) begin
              head      = '{code_point: SUPP_BASE + {12'd0, st.high_sur, u16[9:0]},
                            unit_bytes: 3'd4, is_replacement: 1'b0, last: 1'b0};
              head_emit = 1'b1;
            end else begin
              head      = '{code_point: REPL_CP, unit_bytes: 3'd2,
                            is_replacement: 1'b1, last: 1'b0};
              head_emit = 1'b1;
              broke     = 1'b1;
            end
          end
          // Fresh decode of this unit
          if (!st.sur_pend || broke) begin
            if (u16 < SUR_HI_BASE || u16 >= SUR_END) begin
              fr      = '{code_point: {16'd0, u16}, unit_bytes: 3'd2,
                          is_replacement: 1'b0, last: 1'b0};
              fr_emit = 1'b1;
            end else if (u16 >= SUR_LO_BASE) begin
              fr      = '{code_point: REPL_CP, unit_bytes: 3'd2,
                          is_replacement: 1'b1, last: 1'b0};
              fr_emit = 1'b1;
            end else begin
              st_next.high_sur = u16[9:0];
              st_next.sur_pend = 1'b1;
            end
          end
        end
      end
      default: begin
        if (!cfg.decode_enable) begin
          head      = '{code_point: {24'd0, b}, unit_bytes: 3'd1,
                        is_replacement: 1'b0, last: 1'b0};
          head_emit = 1'b1;
        end else begin
          if (st.seq_pend) begin
            if (b[7:6] != 2'b10) begin
              st_next   = '0;
              head      = '{code_point: REPL_CP, unit_bytes: st.taken,
                            is_replacement: 1'b1, last: 1'b0};
              head_emit = 1'b1;
              broke     = 1'b1;
            end else if (code[31]) begin
              st_next   = '0;
              head      = '{code_point: REPL_CP, unit_bytes: len,
                            is_replacement: 1'b1, last: 1'b0};
              head_emit = 1'b1;
            end else if ((code & CTRL_BIT[st.stage]) != '0) begin
              // Strip the marker bit and wait for the next byte
              st_next.acc   = code & ~CTRL_BIT[st.stage];
              st_next.stage = st.stage + 3'd1;
              st_next.taken = len;
            end else begin
              st_next   = '0;
              head_emit = 1'b1;
              if (code < MIN_VAL[st.stage]) begin
                head = '{code_point: REPL_CP, unit_bytes: len,
                         is_replacement: 1'b1, last: 1'b0};
              end else begin
                head = '{code_point: code, unit_bytes: len,
                         is_replacement: 1'b0, last: 1'b0};
              end
            end
          end
          if (!st.seq_pend || broke) begin
            if (!b[7]) begin
              fr      = '{code_point: {24'd0, b}, unit_bytes: 3'd1,
                          is_replacement: 1'b0, last: 1'b0};
              fr_emit = 1'b1;
            end else if (!b[6] || b >= LEAD_BAD) begin
              fr      = '{code_point: REPL_CP, unit_bytes: 3'd1,
                          is_replacement: 1'b1, last: 1'b0};
              fr_emit = 1'b1;
            end else begin
              st_next.acc      = {26'd0, b[5:0]};
              st_next.stage    = 3'd0;
              st_next.taken    = 3'd1;
              st_next.seq_pend = 1'b1;
            end
          end
        end
      end
    endcase

    // Order the results and flag the final one
    r0 = head;
    r1 = fr;
    n  = {1'b0, head_emit} + {1'b0, fr_emit};
    if (!head_emit) begin
      r0 = fr;
    end
    if (n == 2'd2) begin
      r1.last = 1'b1;
    end else begin
      r0.last = 1'b1;
    end
  end

endmodule

@@ rtl/mwcd_queue.sv @@
module mwcd_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic [1:0]     push_n,
  input  mwcd_pkg::res_t r0,
  input  mwcd_pkg::res_t r1,
  output logic           room,
  output logic           out_valid,
  input  logic           out_ready,
  output mwcd_pkg::res_t out_res
);
  import mwcd_pkg::*;

  res_t                 mem [Q_DEPTH];
  logic [Q_PTR_W-1:0]   wr_ptr, rd_ptr;
  logic [Q_CNT_W-1:0]   count;
  logic                 pop;

  assign out_valid = (count != '0);
  assign out_res   = mem[rd_ptr];
  assign pop       = out_valid & out_ready;
  assign room      = (count <= Q_CNT_W'(Q_DEPTH - 2));

  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      mem[wr_ptr] <= r0;
    end
    if (push_n == 2'd2) begin
      mem[wr_ptr + Q_PTR_W'(1)] <= r1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + Q_PTR_W'(push_n);
      rd_ptr <= rd_ptr + Q_PTR_W'(pop);
      count  <= count + Q_CNT_W'(push_n) - Q_CNT_W'(pop);
    end
  end

endmodule

@@ rtl/multi_width_char_decoder_unit.sv @@
// Multi-width character decoder.
//
// Input channel (in_valid / in_ready / code_unit): one code unit per beat,
// 8, 16 or 32 bits wide as unit_width selects. Output channel (out_valid /
// out_ready): one decoded character per beat with code_point, unit_bytes,
// is_replacement and last; last marks the final result of an input beat.
// Configuration sits on a small APB-style port: unit_width at address 0,
// decode_enable at address 4. Any write drops a half-built sequence.
//
// A result passes the input register, then the result queue, before it is
// offered. Throughput: one input beat per cycle while each unit gives at
// most one result and the receiver takes every result; a unit that breaks
// a sequence gives two results, offered in order on the output.
// The figure is set by the four-entry result queue: a unit is decoded only
// when two entries are free.
//
// Reset clears the input register, the result queue and all pending
// sequence state, and returns to 8-bit UTF-8 decoding. When the receiver
// stalls, results pile up in the queue and then in_ready drops.
module multi_width_char_decoder_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] code_unit,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] code_point,
  output logic [2:0]  unit_bytes,
  output logic        is_replacement,
  output logic        last
);
  import mwcd_pkg::*;

  cfg_t        cfg;
  logic        cfg_wr;
  logic        in_full;
  logic [31:0] unit_q;
  logic        room;
  logic        fire;
  res_t        r0, r1, out_res;
  logic [1:0]  n;

  mwcd_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg),
    .cfg_wr  (cfg_wr)
  );

  // Decode the held unit once the queue can take both possible results
  assign fire     = in_full & room;
  assign in_ready = ~in_full | fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_ready) begin
      in_full <= in_valid;
    end
  end

  // Payload register: capture on every accepted beat
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      unit_q <= code_unit;
    end
  end

  mwcd_decode u_decode (
    .clk   (clk),
    .rst   (rst),
    .cfg   (cfg),
    .clear (cfg_wr),
    .fire  (fire),
    .unit  (unit_q),
    .r0    (r0),
    .r1    (r1),
    .n     (n)
  );

  mwcd_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push_n    (fire ? n : 2'd0),
    .r0        (r0),
    .r1        (r1),
    .room      (room),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (out_res)
  );

  assign code_point     = out_res.code_point;
  assign unit_bytes     = out_res.unit_bytes;
  assign is_replacement = out_res.is_replacement;
  assign last           = out_res.last;

endmodule

@@ rtl/mwcd_checker.sv @@
module mwcd_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] code_point,
  input logic [2:0]  unit_bytes,
  input logic        is_replacement,
  input logic        last
);

  // Queue empties on reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result offered straight after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(code_point)
      && $stable(unit_bytes) && $stable(is_replacement) && $stable(last))
    else $error("stalled result changed");

  a_repl_value: assert property (@(posedge clk) disable iff (rst)
    out_valid && is_replacement |-> code_point == 32'h0000_FFFD)
    else $error("replacement flag without U+FFFD");

  a_bytes_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> unit_bytes != 3'd0 && unit_bytes != 3'd7)
    else $error("byte count out of range");

  // A non-final result is always a replacement for a broken sequence
  a_first_of_two: assert property (@(posedge clk) disable iff (rst)
    out_valid && !last |-> is_replacement)
    else $error("non-final result that is not a replacement");

endmodule

bind multi_width_char_decoder_unit mwcd_checker u_mwcd_checker (
  .clk            (clk),
  .rst            (rst),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .code_point     (code_point),
  .unit_bytes     (unit_bytes),
  .is_replacement (is_replacement),
  .last           (last)
);
